FILE: rtl/vnt_pkg.sv
// ----------------------------------------------------------------------------
// vnt_pkg: shared types and constants
// Table ports, lerp unit transactions and the fixed lattice permutation.
// ----------------------------------------------------------------------------
package vnt_pkg;

   localparam int TABLE_SIZE  = 256;
   localparam int INDEX_BITS  = 8;
   localparam int VALUE_BITS  = 16;
   localparam int COUNT_BITS  = 4;
   localparam int RESULT_BITS = 15;
   localparam int COUNT_RESET = 4;
   localparam int Q14_ONE     = 16384;

   // Input transaction codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Lerp levels: the tag names the level the result belongs to.
   localparam logic [1:0] LVL_CORNER = 2'd0;
   localparam logic [1:0] LVL_X      = 2'd1;
   localparam logic [1:0] LVL_Y      = 2'd2;
   localparam logic [1:0] LVL_Z      = 2'd3;

   typedef struct packed {
      logic                  en;
      logic [INDEX_BITS-1:0] addr;
      logic [VALUE_BITS-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic                  en;
      logic [INDEX_BITS-1:0] addr;
   } tbl_rd_type;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            level;
      logic [VALUE_BITS-1:0] a;
      logic [VALUE_BITS-1:0] b;
   } lerp_req_type;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            level;
      logic [VALUE_BITS-1:0] value;
   } lerp_rsp_type;

   localparam logic [7:0] HASH_ROM [TABLE_SIZE] = '{
      8'd225,8'd155,8'd210,8'd108,8'd175,8'd199,8'd221,8'd144,
      8'd203,8'd116,8'd70 ,8'd213,8'd69 ,8'd158,8'd33 ,8'd252,
      8'd5  ,8'd82 ,8'd173,8'd133,8'd222,8'd139,8'd174,8'd27 ,
      8'd9  ,8'd71 ,8'd90 ,8'd246,8'd75 ,8'd130,8'd91 ,8'd191,
      8'd169,8'd138,8'd2  ,8'd151,8'd194,8'd235,8'd81 ,8'd7  ,
      8'd25 ,8'd113,8'd228,8'd159,8'd205,8'd253,8'd134,8'd142,
      8'd248,8'd65 ,8'd224,8'd217,8'd22 ,8'd121,8'd229,8'd63 ,
      8'd89 ,8'd103,8'd96 ,8'd104,8'd156,8'd17 ,8'd201,8'd129,
      8'd36 ,8'd8  ,8'd165,8'd110,8'd237,8'd117,8'd231,8'd56 ,
      8'd132,8'd211,8'd152,8'd20 ,8'd181,8'd111,8'd239,8'd218,
      8'd170,8'd163,8'd51 ,8'd172,8'd157,8'd47 ,8'd80 ,8'd212,
      8'd176,8'd250,8'd87 ,8'd49 ,8'd99 ,8'd242,8'd136,8'd189,
      8'd162,8'd115,8'd44 ,8'd43 ,8'd124,8'd94 ,8'd150,8'd16 ,
      8'd141,8'd247,8'd32 ,8'd10 ,8'd198,8'd223,8'd255,8'd72 ,
      8'd53 ,8'd131,8'd84 ,8'd57 ,8'd220,8'd197,8'd58 ,8'd50 ,
      8'd208,8'd11 ,8'd241,8'd28 ,8'd3  ,8'd192,8'd62 ,8'd202,
      8'd18 ,8'd215,8'd153,8'd24 ,8'd76 ,8'd41 ,8'd15 ,8'd179,
      8'd39 ,8'd46 ,8'd55 ,8'd6  ,8'd128,8'd167,8'd23 ,8'd188,
      8'd106,8'd34 ,8'd187,8'd140,8'd164,8'd73 ,8'd112,8'd182,
      8'd244,8'd195,8'd227,8'd13 ,8'd35 ,8'd77 ,8'd196,8'd185,
      8'd26 ,8'd200,8'd226,8'd119,8'd31 ,8'd123,8'd168,8'd125,
      8'd249,8'd68 ,8'd183,8'd230,8'd177,8'd135,8'd160,8'd180,
      8'd12 ,8'd1  ,8'd243,8'd148,8'd102,8'd166,8'd38 ,8'd238,
      8'd251,8'd37 ,8'd240,8'd126,8'd64 ,8'd74 ,8'd161,8'd40 ,
      8'd184,8'd149,8'd171,8'd178,8'd101,8'd66 ,8'd29 ,8'd59 ,
      8'd146,8'd61 ,8'd254,8'd107,8'd42 ,8'd86 ,8'd154,8'd4  ,
      8'd236,8'd232,8'd120,8'd21 ,8'd233,8'd209,8'd45 ,8'd98 ,
      8'd193,8'd114,8'd78 ,8'd19 ,8'd206,8'd14 ,8'd118,8'd127,
      8'd48 ,8'd79 ,8'd147,8'd85 ,8'd30 ,8'd207,8'd219,8'd54 ,
      8'd88 ,8'd234,8'd190,8'd122,8'd95 ,8'd67 ,8'd143,8'd109,
      8'd137,8'd214,8'd145,8'd93 ,8'd92 ,8'd100,8'd245,8'd0  ,
      8'd216,8'd186,8'd60 ,8'd83 ,8'd105,8'd97 ,8'd204,8'd52
   };

endpackage

FILE: rtl/value_noise_turbulence_3d.sv
// ----------------------------------------------------------------------------
// value_noise_turbulence_3d: 3-D value-noise turbulence
// Lattice table in RAM, eight corner reads per octave, shared lerp unit.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_*) takes two kinds of transaction. A load
// (req_op = 0) writes req_entry_value into lattice entry req_entry_index and
// gives no response. An evaluate (req_op = 1) takes a Q16.16 point and gives
// one response transaction on rsp_* with the turbulence.
// Every table entry that an evaluation touches must have been loaded first.
// The csr_wr_en / csr_wr_data port sets the octave count; write it only
// while the block is idle.
// Each octave issues eight corner reads through the single RAM read port,
// one a cycle, and the lerp unit reduces them as they return. The block
// accepts one transaction at a time, the next one in the cycle after the
// response is loaded.
// The response sits in an output register, so a new request is accepted
// while it waits; if the receiver still stalls when the next evaluation
// finishes, the block holds that result until rsp_ready frees the register.
// Reset sets the octave count to 4 and empties the pipeline; the table
// contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module value_noise_turbulence_3d #(
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [vnt_pkg::INDEX_BITS-1:0]      req_entry_index,
   input  logic signed [vnt_pkg::VALUE_BITS-1:0] req_entry_value,
   input  logic signed [31:0]                  req_x_coord,
   input  logic signed [31:0]                  req_y_coord,
   input  logic signed [31:0]                  req_z_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vnt_pkg::RESULT_BITS-1:0]     rsp_turbulence,
   input  logic                                csr_wr_en,
   input  logic [vnt_pkg::COUNT_BITS-1:0]      csr_wr_data
);
   import vnt_pkg::*;

   localparam int FB   = COORD_FRAC_BITS;
   localparam int AW   = VALUE_BITS + 2 + MAX_OCTAVES;
   localparam int SH_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type                 state_ff;
   logic [COUNT_BITS-1:0]     octave_count_ff;
   logic [31:0]               x_ff, y_ff, z_ff;
   logic [COUNT_BITS-1:0]     oct_n_ff, oct_k_ff;
   logic [2:0]                corner_ff;
   logic signed [AW-1:0]      acc_ff;
   logic [VALUE_BITS-1:0]     held_ff [3];
   logic [2:0]                held_v_ff;
   logic                      rsp_valid_ff;
   logic [RESULT_BITS-1:0]    rsp_turb_ff;

   tbl_wr_type                tbl_wr;
   tbl_rd_type                tbl_rd;
   logic [VALUE_BITS-1:0]     tbl_data;
   logic                      tbl_valid;
   lerp_req_type              lerp_req;
   lerp_rsp_type              lerp_rsp;
   logic [FB-1:0]             lerp_frac;

   logic [INDEX_BITS-1:0]     ixd, iyd, izd, hash_y, corner_addr;
   logic [COUNT_BITS-1:0]     n_clamped;
   logic                      mem_issue, lerp_issue, lerp_hold, oct_done;
   logic [1:0]                lerp_lvl;
   logic [VALUE_BITS-1:0]     lerp_held;
   logic signed [AW-1:0]      oct_add;
   logic [SH_W-1:0]           oct_shift;
   logic signed [AW-1:0]      acc_floor;
   logic signed [VALUE_BITS+1:0] t_val, t_clamp;
   logic [RESULT_BITS-1:0]    t_abs;
   logic                      rsp_free;

   // Corner address: hash chain over z, then y, then the x offset.
   always_comb begin
      ixd         = x_ff[FB+INDEX_BITS-1:FB] + {{(INDEX_BITS-1){1'b0}}, corner_ff[0]};
      iyd         = y_ff[FB+INDEX_BITS-1:FB] + {{(INDEX_BITS-1){1'b0}}, corner_ff[1]};
      izd         = z_ff[FB+INDEX_BITS-1:FB] + {{(INDEX_BITS-1){1'b0}}, corner_ff[2]};
      hash_y      = iyd + HASH_ROM[izd];
      corner_addr = ixd + HASH_ROM[hash_y];
   end

   always_comb begin
      tbl_wr.en   = req_valid && req_ready && (req_op == OP_LOAD);
      tbl_wr.addr = req_entry_index;
      tbl_wr.data = req_entry_value;
      tbl_rd.en   = (state_ff == ST_READ);
      tbl_rd.addr = corner_addr;
   end

   // Values pair up level by level: the first of a pair is held, the second
   // issues a lerp whose result climbs one level. The schedule of corner
   // returns never lets two lerps issue in one cycle.
   always_comb begin
      mem_issue  = tbl_valid && held_v_ff[0];
      lerp_lvl   = lerp_rsp.level;
      lerp_held  = '0;
      unique case (lerp_lvl)
         LVL_X:   lerp_held = held_ff[1];
         LVL_Y:   lerp_held = held_ff[2];
         default: lerp_held = '0;
      endcase
      lerp_hold  = lerp_rsp.valid && (lerp_lvl != LVL_Z);
      lerp_issue = lerp_hold && (((lerp_lvl == LVL_X) && held_v_ff[1]) ||
                                 ((lerp_lvl == LVL_Y) && held_v_ff[2]));
      lerp_req.valid = mem_issue || lerp_issue;
      if (mem_issue) begin
         lerp_req.level = LVL_X;
         lerp_req.a     = held_ff[0];
         lerp_req.b     = tbl_data;
      end else begin
         lerp_req.level = lerp_lvl + 2'd1;
         lerp_req.a     = lerp_held;
         lerp_req.b     = lerp_rsp.value;
      end
      unique case (lerp_req.level)
         LVL_X:   lerp_frac = x_ff[FB-1:0];
         LVL_Y:   lerp_frac = y_ff[FB-1:0];
         default: lerp_frac = z_ff[FB-1:0];
      endcase
   end

   always_comb begin
      n_clamped = ({1'b0, octave_count_ff} > (COUNT_BITS+1)'(MAX_OCTAVES)) ?
                  COUNT_BITS'(MAX_OCTAVES) : octave_count_ff;
      oct_done  = lerp_rsp.valid && (lerp_lvl == LVL_Z);
      oct_shift = SH_W'(MAX_OCTAVES - 1) - SH_W'(oct_k_ff);
      oct_add   = AW'($signed(lerp_rsp.value)) <<< oct_shift;
      acc_floor = acc_ff >>> MAX_OCTAVES;
      t_val     = acc_floor[VALUE_BITS+1:0];
      if (t_val > $signed((VALUE_BITS+2)'(Q14_ONE))) begin
         t_clamp = (VALUE_BITS+2)'(Q14_ONE);
      end else if (t_val < -$signed((VALUE_BITS+2)'(Q14_ONE))) begin
         t_clamp = -$signed((VALUE_BITS+2)'(Q14_ONE));
      end else begin
         t_clamp = t_val;
      end
      t_abs     = t_clamp[VALUE_BITS+1] ? RESULT_BITS'(-t_clamp) : RESULT_BITS'(t_clamp);
      rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         octave_count_ff <= COUNT_BITS'(COUNT_RESET);
         held_v_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         corner_ff       <= '0;
         oct_k_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            octave_count_ff <= csr_wr_data;
         end
         if ((state_ff == ST_FINISH) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (tbl_valid) begin
            held_v_ff[0] <= !held_v_ff[0];
            if (!held_v_ff[0]) begin
               held_ff[0] <= tbl_data;
            end
         end
         if (lerp_hold) begin
            unique case (lerp_lvl)
               LVL_X: begin
                  held_v_ff[1] <= !held_v_ff[1];
                  if (!held_v_ff[1]) begin
                     held_ff[1] <= lerp_rsp.value;
                  end
               end
               default: begin
                  held_v_ff[2] <= !held_v_ff[2];
                  if (!held_v_ff[2]) begin
                     held_ff[2] <= lerp_rsp.value;
                  end
               end
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_op == OP_EVAL)) begin
                  x_ff      <= req_x_coord;
                  y_ff      <= req_y_coord;
                  z_ff      <= req_z_coord;
                  oct_n_ff  <= n_clamped;
                  oct_k_ff  <= '0;
                  corner_ff <= '0;
                  acc_ff    <= '0;
                  state_ff  <= (n_clamped == '0) ? ST_FINISH : ST_READ;
               end
            end
            ST_READ: begin
               corner_ff <= corner_ff + 3'd1;
               if (corner_ff == 3'd7) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (oct_done) begin
                  acc_ff   <= acc_ff + oct_add;
                  oct_k_ff <= oct_k_ff + COUNT_BITS'(1);
                  x_ff     <= {x_ff[30:0], 1'b0};
                  y_ff     <= {y_ff[30:0], 1'b0};
                  z_ff     <= {z_ff[30:0], 1'b0};
                  state_ff <= (oct_k_ff + COUNT_BITS'(1) == oct_n_ff) ? ST_FINISH : ST_READ;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_turb_ff  <= t_abs;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_turbulence = rsp_turb_ff;

   vnt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd       (tbl_rd),
      .rd_data  (tbl_data),
      .rd_valid (tbl_valid)
   );

   vnt_lerp #(.FRAC_BITS(FB)) u_lerp (
      .clock (clock),
      .reset (reset),
      .req   (lerp_req),
      .frac  (lerp_frac),
      .rsp   (lerp_rsp)
   );

   a_one_lerp_issue: assert property (@(posedge clock) disable iff (reset)
      !(mem_issue && lerp_issue))
      else $error("corner and level lerps issued in the same cycle");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (held_v_ff == 3'b000 && !lerp_rsp.valid && !tbl_valid))
      else $error("interpolation left partial values after an octave");

   a_octave_end_in_wait: assert property (@(posedge clock) disable iff (reset)
      oct_done |-> (state_ff == ST_WAIT))
      else $error("octave result arrived outside the wait state");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> rsp_valid_ff)
      else $error("finished evaluation did not produce a response");

endmodule

FILE: rtl/vnt_table.sv
// ----------------------------------------------------------------------------
// vnt_table: lattice value memory
// 256 x 16 synchronous RAM, one write port and one read port with a
// registered read and a matching data-valid flag.
// ----------------------------------------------------------------------------
module vnt_table (
   input  logic                       clock,
   input  logic                       reset,
   input  vnt_pkg::tbl_wr_type        wr,
   input  vnt_pkg::tbl_rd_type        rd,
   output logic [vnt_pkg::VALUE_BITS-1:0] rd_data,
   output logic                       rd_valid
);
   import vnt_pkg::*;

   logic [VALUE_BITS-1:0] mem [TABLE_SIZE];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd.en;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

FILE: rtl/vnt_lerp.sv
// ----------------------------------------------------------------------------
// vnt_lerp: registered linear interpolation unit
// Computes a + floor(f * (b - a) / 2^FRAC_BITS) and carries the level tag.
// ----------------------------------------------------------------------------
module vnt_lerp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vnt_pkg::lerp_req_type req,
   input  logic [FRAC_BITS-1:0]  frac,
   output vnt_pkg::lerp_rsp_type rsp
);
   import vnt_pkg::*;

   logic signed [VALUE_BITS:0]          diff;
   logic signed [FRAC_BITS+VALUE_BITS+1:0] prod;
   logic signed [VALUE_BITS+1:0]        step;
   logic signed [VALUE_BITS+1:0]        sum;
   logic                                valid_ff;
   logic [1:0]                          level_ff;
   logic [VALUE_BITS-1:0]               value_ff;

   always_comb begin
      diff = $signed({req.b[VALUE_BITS-1], req.b}) - $signed({req.a[VALUE_BITS-1], req.a});
      prod = $signed({1'b0, frac}) * diff;
      // The arithmetic shift floors toward minus infinity.
      step = (VALUE_BITS+2)'(prod >>> FRAC_BITS);
      sum  = $signed({{2{req.a[VALUE_BITS-1]}}, req.a}) + step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req.valid;
      end
      level_ff <= req.level;
      value_ff <= sum[VALUE_BITS-1:0];
   end

   assign rsp.valid = valid_ff;
   assign rsp.level = level_ff;
   assign rsp.value = value_ff;

endmodule
